// File: rtl/vfcm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vfcm_pkg
// Shared types, codes and texture lookup for the voxel face culling mesher.
// ----------------------------------------------------------------------------
package vfcm_pkg;

  localparam int EDGE_LEN_DEF = 16;
  // Atlas is 16 cells wide: column is the low nibble of the id, row the rest.
  localparam int ATLAS_COLS   = 16;
  localparam int TEX_W        = 7;
  localparam int QIDX_W       = 15;
  localparam logic [QIDX_W-1:0] QUAD_LAST = 15'd24575;

  localparam logic [1:0] FN_WRITE = 2'd0;
  localparam logic [1:0] FN_MESH  = 2'd1;
  localparam logic [1:0] FN_CLEAR = 2'd2;

  localparam logic [3:0] KIND_AIR    = 4'd0;
  localparam logic [3:0] KIND_DIRT   = 4'd1;
  localparam logic [3:0] KIND_GRASS  = 4'd2;
  localparam logic [3:0] KIND_STONE  = 4'd3;
  localparam logic [3:0] KIND_SOLID  = 4'd4;
  localparam logic [3:0] KIND_BOUNCE = 4'd5;
  localparam logic [3:0] KIND_ICE    = 4'd6;
  localparam logic [3:0] KIND_TRACK  = 4'd7;
  localparam logic [3:0] KIND_MUD    = 4'd8;
  localparam logic [3:0] KIND_GIFT   = 4'd9;
  localparam logic [3:0] KIND_TABLE  = 4'd10;

  localparam logic [2:0] FACE_ZN = 3'd0;
  localparam logic [2:0] FACE_ZP = 3'd1;
  localparam logic [2:0] FACE_XN = 3'd2;
  localparam logic [2:0] FACE_XP = 3'd3;
  localparam logic [2:0] FACE_YN = 3'd4;
  localparam logic [2:0] FACE_YP = 3'd5;

  typedef struct packed {
    logic [1:0] func;
    logic [3:0] pos_x;
    logic [3:0] pos_y;
    logic [3:0] pos_z;
    logic [3:0] block_kind;
  } req_t;

  typedef struct packed {
    logic [3:0]        quad_x;
    logic [3:0]        quad_y;
    logic [3:0]        quad_z;
    logic [2:0]        face_id;
    logic [3:0]        atlas_col;
    logic [3:0]        atlas_row;
    logic [QIDX_W-1:0] quad_index;
    logic              last_quad;
  } quad_t;

  // Work handed from the sequencer to the emitter.
  typedef struct packed {
    logic       clr;
    logic [3:0] kind;
    logic [5:0] mask;   // exposed faces in emission order z-,z+,y-,y+,x-,x+
    logic [3:0] x;
    logic [3:0] y;
    logic [3:0] z;
  } job_t;

  function automatic logic [2:0] face_of(input logic [2:0] slot);
    logic [2:0] f;
    case (slot)
      3'd0:    f = FACE_ZN;
      3'd1:    f = FACE_ZP;
      3'd2:    f = FACE_YN;
      3'd3:    f = FACE_YP;
      3'd4:    f = FACE_XN;
      default: f = FACE_XP;
    endcase
    return f;
  endfunction

  function automatic logic [TEX_W-1:0] tex_id(input logic [3:0] kind, input logic [2:0] face);
    logic [TEX_W-1:0] t;
    case (kind)
      KIND_DIRT:   t = 7'd2;
      KIND_GRASS:  t = (face == FACE_ZN) ? 7'd2 : ((face == FACE_ZP) ? 7'd0 : 7'd3);
      KIND_STONE:  t = 7'd16;
      KIND_SOLID:  t = 7'd17;
      KIND_BOUNCE: t = 7'd23;
      KIND_ICE:    t = 7'd67;
      KIND_TRACK:  t = 7'd7;
      KIND_MUD:    t = 7'd86;
      KIND_GIFT:   t = 7'd35;
      KIND_TABLE: begin
        if (face == FACE_ZN || face == FACE_ZP) t = 7'd43;
        else if (face == FACE_XN)               t = 7'd60;
        else                                    t = 7'd59;
      end
      default:     t = 7'd24;
    endcase
    return t;
  endfunction

endpackage
`default_nettype wire

// File: rtl/voxel_face_culling_mesher_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// voxel_face_culling_mesher_unit
// Voxel chunk store with hidden-face culling: writes voxel types and emits
// one quad descriptor per exposed face of a meshed non-air voxel.
// ----------------------------------------------------------------------------
// A mesh makes seven reads of the single-port voxel memory, then hands the
// face mask to the emitter, which sends one quad a cycle unless quad_stall
// holds it. One request at a time; the next may enter while quads still go out.
// Reset: after rst the store is swept to air, one entry a cycle, across all
// 2**(3*clog2(EDGE_LEN)) entries (4096 at EDGE_LEN 16) with req_stall high.
module voxel_face_culling_mesher_unit
  import vfcm_pkg::*;
#(
  parameter int EDGE_LEN = EDGE_LEN_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_stall,
  input  wire req_t req,
  output logic      quad_valid,
  input  wire logic quad_stall,
  output quad_t     quad
);

  localparam int AW = 3 * $clog2(EDGE_LEN);

  logic          job_valid;
  logic          job_ready;
  job_t          job;
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [3:0]    ram_wdata;
  logic [3:0]    ram_rdata;

  vfcm_ram #(.AW(AW)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  vfcm_seq #(.EDGE_LEN(EDGE_LEN)) u_seq (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job       (job),
    .ram_we    (ram_we),
    .ram_addr  (ram_addr),
    .ram_wdata (ram_wdata),
    .ram_rdata (ram_rdata)
  );

  vfcm_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .job_valid  (job_valid),
    .job_ready  (job_ready),
    .job        (job),
    .quad_valid (quad_valid),
    .quad_stall (quad_stall),
    .quad       (quad)
  );

endmodule
`default_nettype wire

// File: rtl/vfcm_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vfcm_ram
// Single-port voxel type memory, registered read data.
// ----------------------------------------------------------------------------
module vfcm_ram #(
  parameter int AW = 12
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] addr,
  input  wire logic [3:0]    wdata,
  output logic      [3:0]    rdata
);

  logic [3:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else begin
      rdata <= mem[addr];
    end
  end

endmodule
`default_nettype wire

// File: rtl/vfcm_seq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vfcm_seq
// Request sequencer: clears the store after reset, performs writes and reads
// a voxel plus its six neighbors to build the exposed-face mask, forwards clears.
// ----------------------------------------------------------------------------
module vfcm_seq
  import vfcm_pkg::*;
#(
  parameter int EDGE_LEN = EDGE_LEN_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_stall,
  input  wire req_t req,
  output logic      job_valid,
  input  wire logic job_ready,
  output job_t      job,
  output logic      ram_we,
  output logic [3*$clog2(EDGE_LEN)-1:0] ram_addr,
  output logic [3:0] ram_wdata,
  input  wire logic [3:0] ram_rdata
);

  localparam int CW = $clog2(EDGE_LEN);
  localparam int AW = 3 * CW;
  localparam int XW = (CW > 4) ? CW : 4;
  localparam logic [XW-1:0] LIM_X = XW'(EDGE_LEN - 1);
  localparam logic [CW-1:0] LIM   = CW'(EDGE_LEN - 1);

  typedef enum logic [2:0] {S_CLR, S_IDLE, S_WR, S_RD, S_FIN, S_HAND} state_t;

  state_t        state;
  logic [AW-1:0] clr_cnt;
  logic [2:0]    rd_idx;
  logic          rd_vld;
  logic [2:0]    rd_tag;
  logic [CW-1:0] cx, cy, cz;
  logic [3:0]    kind_w;
  logic [3:0]    ox, oy, oz;
  logic          clr_job;
  logic [3:0]    self_kind;
  logic [5:0]    mask;

  logic [XW-1:0] xin, yin, zin;
  logic          in_range;
  logic          accept;
  logic [5:0]    edge_hit;
  logic [AW-1:0] self_addr;
  logic [AW-1:0] nb_addr;

  assign xin      = XW'(req.pos_x);
  assign yin      = XW'(req.pos_y);
  assign zin      = XW'(req.pos_z);
  assign in_range = (xin <= LIM_X) && (yin <= LIM_X) && (zin <= LIM_X);
  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;

  assign edge_hit  = {cx == LIM, cx == '0, cy == LIM, cy == '0, cz == LIM, cz == '0};
  assign self_addr = {cx, cy, cz};

  always_comb begin
    case (rd_idx)
      3'd1:    nb_addr = {cx, cy, cz - CW'(1)};
      3'd2:    nb_addr = {cx, cy, cz + CW'(1)};
      3'd3:    nb_addr = {cx, cy - CW'(1), cz};
      3'd4:    nb_addr = {cx, cy + CW'(1), cz};
      3'd5:    nb_addr = {cx - CW'(1), cy, cz};
      3'd6:    nb_addr = {cx + CW'(1), cy, cz};
      default: nb_addr = self_addr;
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = kind_w;
    ram_addr  = self_addr;
    case (state)
      S_CLR: begin
        ram_we    = 1'b1;
        ram_wdata = KIND_AIR;
        ram_addr  = clr_cnt;
      end
      S_WR: begin
        ram_we = 1'b1;
      end
      S_RD: begin
        ram_addr = nb_addr;
      end
      default: ;
    endcase
  end

  assign job_valid = (state == S_HAND);
  assign job.clr   = clr_job;
  assign job.kind  = self_kind;
  assign job.mask  = mask;
  assign job.x     = ox;
  assign job.y     = oy;
  assign job.z     = oz;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLR;
      clr_cnt <= '0;
      rd_idx  <= '0;
      rd_vld  <= 1'b0;
    end else begin
      rd_vld <= (state == S_RD);
      rd_tag <= rd_idx;
      case (state)
        S_CLR: begin
          clr_cnt <= clr_cnt + AW'(1);
          if (&clr_cnt) state <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) begin
            cx      <= xin[CW-1:0];
            cy      <= yin[CW-1:0];
            cz      <= zin[CW-1:0];
            ox      <= req.pos_x;
            oy      <= req.pos_y;
            oz      <= req.pos_z;
            kind_w  <= req.block_kind;
            rd_idx  <= '0;
            clr_job <= (req.func == FN_CLEAR);
            if (req.func == FN_CLEAR) begin
              state <= S_HAND;
            end else if (in_range && req.func == FN_WRITE) begin
              state <= S_WR;
            end else if (in_range && req.func == FN_MESH) begin
              state <= S_RD;
            end
          end
        end
        S_WR: state <= S_IDLE;
        S_RD: begin
          if (rd_idx == 3'd6) state <= S_FIN;
          else                rd_idx <= rd_idx + 3'd1;
        end
        S_FIN: state <= S_HAND;
        S_HAND: begin
          if (job_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Capture read data in the cycle after each issued address.
  always_ff @(posedge clk) begin
    if (rd_vld) begin
      if (rd_tag == 3'd0) self_kind <= ram_rdata;
      for (int i = 0; i < 6; i++) begin
        if (rd_tag == 3'(i + 1)) mask[i] <= edge_hit[i] || (ram_rdata == KIND_AIR);
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/vfcm_emit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vfcm_emit
// Quad emitter: walks the exposed-face mask, looks up texture cells, stamps
// the running quad index and holds each quad in the output register.
// ----------------------------------------------------------------------------
module vfcm_emit
  import vfcm_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic job_valid,
  output logic      job_ready,
  input  wire job_t job,
  output logic      quad_valid,
  input  wire logic quad_stall,
  output quad_t     quad
);

  logic              busy;
  logic [5:0]        rem;
  logic [3:0]        kind;
  logic [3:0]        jx, jy, jz;
  logic [QIDX_W-1:0] quad_count;

  logic [2:0]        sel;
  logic [5:0]        rem_next;
  logic [2:0]        face;
  logic [TEX_W-1:0]  tex;
  logic              advance;

  assign job_ready = !busy;
  assign advance   = busy && (!quad_valid || !quad_stall);

  always_comb begin
    sel = 3'd0;
    for (int i = 5; i >= 0; i--) begin
      if (rem[i]) sel = 3'(i);
    end
  end

  assign rem_next = rem & ~(6'b1 << sel);
  assign face     = face_of(sel);
  assign tex      = tex_id(kind, face);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      quad_valid <= 1'b0;
      quad_count <= '0;
    end else begin
      if (quad_valid && !quad_stall) quad_valid <= 1'b0;
      if (job_valid && !busy) begin
        if (job.clr) begin
          quad_count <= '0;
        end else begin
          busy <= (job.kind != KIND_AIR) && (job.mask != '0);
        end
      end
      if (advance) begin
        quad_valid <= 1'b1;
        busy       <= (rem_next != '0);
        quad_count <= (quad_count == QUAD_LAST) ? '0 : quad_count + QIDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_valid && !busy) begin
      rem  <= job.mask;
      kind <= job.kind;
      jx   <= job.x;
      jy   <= job.y;
      jz   <= job.z;
    end
    if (advance) begin
      rem             <= rem_next;
      quad.quad_x     <= jx;
      quad.quad_y     <= jy;
      quad.quad_z     <= jz;
      quad.face_id    <= face;
      quad.atlas_col  <= tex[3:0];
      quad.atlas_row  <= 4'(tex[TEX_W-1:4]);
      quad.quad_index <= quad_count;
      quad.last_quad  <= (rem_next == '0);
    end
  end

endmodule
`default_nettype wire
